>>> hdl/slpg_pkg.sv
// ----------------------------------------------------------------------------
// Styled line pixel generator package
// Shared constants, item codes and register indexes of the line generator.
// ----------------------------------------------------------------------------
`default_nettype none

package slpg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int QUEUE_DEPTH    = 2;

    localparam int KIND_BITS      = 2;
    localparam int MODE_BITS      = 2;
    localparam int COLOR_BITS     = 8;
    localparam int PATTERN_BITS   = 32;
    localparam int PAT_POS_BITS   = $clog2(PATTERN_BITS);
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [KIND_BITS-1:0] KIND_START = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_STEP  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_POINT = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_FG  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_BG  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_XOR = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WRITE_MODE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STYLED_ENABLE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_PATTERN  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FG_COLOR      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BG_COLOR      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_XOR_COLOR     = 3'd5;

    localparam logic [PATTERN_BITS-1:0] PATTERN_RESET = 32'hffff_ffff;
    localparam logic [COLOR_BITS-1:0]   FG_RESET      = 8'd1;
    localparam logic [COLOR_BITS-1:0]   BG_RESET      = 8'd0;
    localparam logic [COLOR_BITS-1:0]   XOR_RESET     = 8'd255;

    // Width of one queued job: code, four coordinates, two doubled deltas,
    // three direction flags and the error term.
    function automatic int job_bits(input int coord_bits);
        return KIND_BITS + 4 * coord_bits + 2 * (coord_bits + 1) + 3 + (coord_bits + 3);
    endfunction

endpackage

`default_nettype wire

>>> hdl/slpg_cmd_if.sv
// ----------------------------------------------------------------------------
// Line command channel
// Carries start, step and point commands with their endpoint coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface slpg_cmd_if #(
    parameter int COORD_BITS = slpg_pkg::COORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic [slpg_pkg::KIND_BITS-1:0] kind;
    logic [COORD_BITS-1:0]          start_x;
    logic [COORD_BITS-1:0]          start_y;
    logic [COORD_BITS-1:0]          end_x;
    logic [COORD_BITS-1:0]          end_y;

    modport source (
        output valid, kind, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, kind, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/slpg_pixel_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Carries one generated pixel with its draw flag, operation and color.
// ----------------------------------------------------------------------------
`default_nettype none

interface slpg_pixel_if #(
    parameter int COORD_BITS = slpg_pkg::COORD_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [COORD_BITS-1:0]           pixel_x;
    logic [COORD_BITS-1:0]           pixel_y;
    logic                            draw;
    logic                            pixel_op;
    logic [slpg_pkg::COLOR_BITS-1:0] color;
    logic                            last;

    modport source (
        output valid, pixel_x, pixel_y, draw, pixel_op, color, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, draw, pixel_op, color, last,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/slpg_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data written to that register.
// ----------------------------------------------------------------------------
`default_nettype none

interface slpg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [slpg_pkg::CFG_INDEX_BITS-1:0] index;
    logic [slpg_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/slpg_front.sv
// ----------------------------------------------------------------------------
// Line generator front end
// Classifies commands and computes the line setup terms for start commands.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_front #(
    parameter int COORD_BITS = slpg_pkg::COORD_BITS_DEF
) (
    slpg_cmd_if.sink                                      cmd,
    output logic                                          job_valid,
    input  wire logic                                     job_ready,
    output logic [slpg_pkg::job_bits(COORD_BITS)-1:0]     job_data
);

    localparam int C  = COORD_BITS;
    localparam int EB = COORD_BITS + 3;

    typedef struct packed {
        logic [slpg_pkg::KIND_BITS-1:0] op;
        logic [C-1:0]                   sx;
        logic [C-1:0]                   sy;
        logic [C-1:0]                   ex;
        logic [C-1:0]                   ey;
        logic [C:0]                     tadx;
        logic [C:0]                     tady;
        logic                           xneg;
        logic                           yneg;
        logic                           xmaj;
        logic signed [EB-1:0]           err;
    } job_t;

    job_t          job;
    logic          known_kind;
    logic [C:0]    dx;
    logic [C:0]    dy;
    logic [C-1:0]  abs_dx;
    logic [C-1:0]  abs_dy;
    logic [C:0]    tadx;
    logic [C:0]    tady;
    logic          xmaj;

    always_comb
    begin
        case (cmd.kind)
            slpg_pkg::KIND_START,
            slpg_pkg::KIND_STEP,
            slpg_pkg::KIND_POINT: known_kind = 1'b1;
            default:              known_kind = 1'b0;
        endcase
    end

    assign dx     = {1'b0, cmd.end_x} - {1'b0, cmd.start_x};
    assign dy     = {1'b0, cmd.end_y} - {1'b0, cmd.start_y};
    assign abs_dx = dx[C] ? C'(~dx + 1'b1) : dx[C-1:0];
    assign abs_dy = dy[C] ? C'(~dy + 1'b1) : dy[C-1:0];
    assign tadx   = {abs_dx, 1'b0};
    assign tady   = {abs_dy, 1'b0};
    assign xmaj   = tadx > tady;

    always_comb
    begin
        job.op   = cmd.kind;
        job.sx   = cmd.start_x;
        job.sy   = cmd.start_y;
        job.ex   = cmd.end_x;
        job.ey   = cmd.end_y;
        job.tadx = tadx;
        job.tady = tady;
        job.xneg = dx[C];
        job.yneg = dy[C];
        job.xmaj = xmaj;
        if (xmaj)
        begin
            job.err = $signed({2'b00, tady}) - $signed({3'b000, abs_dx});
        end
        else
        begin
            job.err = $signed({2'b00, tadx}) - $signed({3'b000, abs_dy});
        end
    end

    // Unused kinds are taken and dropped here.
    assign cmd.ready = job_ready;
    assign job_valid = cmd.valid && known_kind;
    assign job_data  = job;

endmodule

`default_nettype wire

>>> hdl/slpg_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short register queue that decouples the front end from the pixel stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = slpg_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB = $clog2(DEPTH + 1);
    localparam logic [PB-1:0] LAST_SLOT = PB'(DEPTH - 1);
    localparam logic [CB-1:0] FULL_COUNT = CB'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PB-1:0]    wr_ptr_reg;
    logic [PB-1:0]    wr_ptr_next;
    logic [PB-1:0]    rd_ptr_reg;
    logic [PB-1:0]    rd_ptr_next;
    logic [CB-1:0]    count_reg;
    logic [CB-1:0]    count_next;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != FULL_COUNT;
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count exceeds depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on a push");

    a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on a pop");

endmodule

`default_nettype wire

>>> hdl/slpg_back.sv
// ----------------------------------------------------------------------------
// Line generator back end
// Holds the configuration and line state, steps the line and drives pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module slpg_back #(
    parameter int COORD_BITS = slpg_pkg::COORD_BITS_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      job_valid,
    output logic                                           job_ready,
    input  wire logic [slpg_pkg::job_bits(COORD_BITS)-1:0] job_data,
    slpg_cfg_if.sink                                       cfg,
    slpg_pixel_if.source                                   pixel
);

    localparam int C  = COORD_BITS;
    localparam int EB = COORD_BITS + 3;
    localparam int PB = slpg_pkg::PAT_POS_BITS;
    localparam int KB = slpg_pkg::COLOR_BITS;
    localparam logic [C-1:0] ONE = C'(1);

    typedef struct packed {
        logic [slpg_pkg::KIND_BITS-1:0] op;
        logic [C-1:0]                   sx;
        logic [C-1:0]                   sy;
        logic [C-1:0]                   ex;
        logic [C-1:0]                   ey;
        logic [C:0]                     tadx;
        logic [C:0]                     tady;
        logic                           xneg;
        logic                           yneg;
        logic                           xmaj;
        logic signed [EB-1:0]           err;
    } job_t;

    job_t job;

    logic [slpg_pkg::MODE_BITS-1:0]    write_mode_reg;
    logic                              styled_reg;
    logic [slpg_pkg::PATTERN_BITS-1:0] pattern_reg;
    logic [KB-1:0]                     fg_reg;
    logic [KB-1:0]                     bg_reg;
    logic [KB-1:0]                     xor_reg;

    logic [C-1:0]         cur_x_reg,  cur_x_next;
    logic [C-1:0]         cur_y_reg,  cur_y_next;
    logic [C-1:0]         stop_x_reg, stop_x_next;
    logic [C-1:0]         stop_y_reg, stop_y_next;
    logic signed [EB-1:0] err_reg,    err_next;
    logic [C:0]           tadx_reg,   tadx_next;
    logic [C:0]           tady_reg,   tady_next;
    logic                 xneg_reg,   xneg_next;
    logic                 yneg_reg,   yneg_next;
    logic                 xmaj_reg,   xmaj_next;
    logic [PB-1:0]        pos_reg,    pos_next;
    logic                 active_reg, active_next;

    logic          pix_valid_reg, pix_valid_next;
    logic [C-1:0]  pix_x_reg,     pix_x_next;
    logic [C-1:0]  pix_y_reg,     pix_y_next;
    logic          pix_draw_reg,  pix_draw_next;
    logic          pix_op_reg,    pix_op_next;
    logic [KB-1:0] pix_color_reg, pix_color_next;
    logic          pix_last_reg,  pix_last_next;

    logic                 take;
    logic                 mode_ok;
    logic                 mode_op;
    logic [KB-1:0]        mode_color;
    logic                 line_last;
    logic                 minor_step;
    logic signed [EB-1:0] tadx_s;
    logic signed [EB-1:0] tady_s;

    function automatic logic [C-1:0] step_coord(input logic [C-1:0] v, input logic neg);
        return neg ? v - ONE : v + ONE;
    endfunction

    assign job       = job_t'(job_data);
    assign job_ready = !pix_valid_reg || pixel.ready;
    assign take      = job_valid && job_ready;
    assign cfg.ready = 1'b1;

    assign tadx_s = $signed({2'b00, tadx_reg});
    assign tady_s = $signed({2'b00, tady_reg});

    always_comb
    begin
        unique case (write_mode_reg)
            slpg_pkg::MODE_FG:
            begin
                mode_ok = 1'b1; mode_op = 1'b0; mode_color = fg_reg;
            end
            slpg_pkg::MODE_BG:
            begin
                mode_ok = 1'b1; mode_op = 1'b0; mode_color = bg_reg;
            end
            slpg_pkg::MODE_XOR:
            begin
                mode_ok = 1'b1; mode_op = 1'b1; mode_color = xor_reg;
            end
            default:
            begin
                mode_ok = 1'b0; mode_op = 1'b0; mode_color = '0;
            end
        endcase
    end

    assign line_last  = xmaj_reg ? (cur_x_reg == stop_x_reg) : (cur_y_reg == stop_y_reg);
    assign minor_step = (err_reg > 0) ||
                        (err_reg == 0 && !(xmaj_reg ? xneg_reg : yneg_reg));

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        stop_x_next    = stop_x_reg;
        stop_y_next    = stop_y_reg;
        err_next       = err_reg;
        tadx_next      = tadx_reg;
        tady_next      = tady_reg;
        xneg_next      = xneg_reg;
        yneg_next      = yneg_reg;
        xmaj_next      = xmaj_reg;
        pos_next       = pos_reg;
        active_next    = active_reg;
        pix_valid_next = pix_valid_reg && !pixel.ready;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        pix_draw_next  = pix_draw_reg;
        pix_op_next    = pix_op_reg;
        pix_color_next = pix_color_reg;
        pix_last_next  = pix_last_reg;

        if (take)
        begin
            case (job.op)
                slpg_pkg::KIND_START:
                begin
                    cur_x_next  = job.sx;
                    cur_y_next  = job.sy;
                    stop_x_next = job.ex;
                    stop_y_next = job.ey;
                    err_next    = job.err;
                    tadx_next   = job.tadx;
                    tady_next   = job.tady;
                    xneg_next   = job.xneg;
                    yneg_next   = job.yneg;
                    xmaj_next   = job.xmaj;
                    pos_next    = '0;
                    active_next = 1'b1;
                end
                slpg_pkg::KIND_POINT:
                begin
                    pix_valid_next = 1'b1;
                    pix_x_next     = job.sx;
                    pix_y_next     = job.sy;
                    pix_draw_next  = mode_ok;
                    pix_op_next    = mode_op;
                    pix_color_next = mode_color;
                    pix_last_next  = 1'b1;
                end
                slpg_pkg::KIND_STEP:
                begin
                    if (active_reg)
                    begin
                        pix_valid_next = 1'b1;
                        pix_x_next     = cur_x_reg;
                        pix_y_next     = cur_y_reg;
                        pix_op_next    = mode_op;
                        pix_color_next = mode_color;
                        pix_last_next  = line_last;
                        if (styled_reg)
                        begin
                            // The pattern is read from its most significant bit down.
                            pix_draw_next = pattern_reg[~pos_reg];
                            pos_next      = pos_reg + 1'b1;
                        end
                        else
                        begin
                            pix_draw_next = 1'b1;
                        end
                        if (line_last)
                        begin
                            active_next = 1'b0;
                        end
                        else if (xmaj_reg)
                        begin
                            cur_x_next = step_coord(cur_x_reg, xneg_reg);
                            cur_y_next = minor_step ? step_coord(cur_y_reg, yneg_reg)
                                                    : cur_y_reg;
                            err_next   = err_reg + tady_s - (minor_step ? tadx_s : '0);
                        end
                        else
                        begin
                            cur_y_next = step_coord(cur_y_reg, yneg_reg);
                            cur_x_next = minor_step ? step_coord(cur_x_reg, xneg_reg)
                                                    : cur_x_reg;
                            err_next   = err_reg + tadx_s - (minor_step ? tady_s : '0);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_mode_reg <= slpg_pkg::MODE_FG;
            styled_reg     <= 1'b0;
            pattern_reg    <= slpg_pkg::PATTERN_RESET;
            fg_reg         <= slpg_pkg::FG_RESET;
            bg_reg         <= slpg_pkg::BG_RESET;
            xor_reg        <= slpg_pkg::XOR_RESET;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            stop_x_reg     <= '0;
            stop_y_reg     <= '0;
            err_reg        <= '0;
            tadx_reg       <= '0;
            tady_reg       <= '0;
            xneg_reg       <= 1'b0;
            yneg_reg       <= 1'b0;
            xmaj_reg       <= 1'b0;
            pos_reg        <= '0;
            active_reg     <= 1'b0;
            pix_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    slpg_pkg::CFG_WRITE_MODE:    write_mode_reg <= cfg.data[slpg_pkg::MODE_BITS-1:0];
                    slpg_pkg::CFG_STYLED_ENABLE: styled_reg     <= cfg.data[0];
                    slpg_pkg::CFG_LINE_PATTERN:  pattern_reg    <= cfg.data;
                    slpg_pkg::CFG_FG_COLOR:      fg_reg         <= cfg.data[KB-1:0];
                    slpg_pkg::CFG_BG_COLOR:      bg_reg         <= cfg.data[KB-1:0];
                    slpg_pkg::CFG_XOR_COLOR:     xor_reg        <= cfg.data[KB-1:0];
                    default:
                    begin
                    end
                endcase
            end
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            stop_x_reg    <= stop_x_next;
            stop_y_reg    <= stop_y_next;
            err_reg       <= err_next;
            tadx_reg      <= tadx_next;
            tady_reg      <= tady_next;
            xneg_reg      <= xneg_next;
            yneg_reg      <= yneg_next;
            xmaj_reg      <= xmaj_next;
            pos_reg       <= pos_next;
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        pix_draw_reg  <= pix_draw_next;
        pix_op_reg    <= pix_op_next;
        pix_color_reg <= pix_color_next;
        pix_last_reg  <= pix_last_next;
    end

    assign pixel.valid    = pix_valid_reg;
    assign pixel.pixel_x  = pix_x_reg;
    assign pixel.pixel_y  = pix_y_reg;
    assign pixel.draw     = pix_draw_reg;
    assign pixel.pixel_op = pix_op_reg;
    assign pixel.color    = pix_color_reg;
    assign pixel.last     = pix_last_reg;

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (take && job.op == slpg_pkg::KIND_START) |=> active_reg && pos_reg == '0)
        else $error("start did not arm the line");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (take && job.op == slpg_pkg::KIND_STEP && active_reg && line_last)
        |=> !active_reg && pix_valid_reg && pix_last_reg)
        else $error("final pixel did not end the line");

    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (take && job.op == slpg_pkg::KIND_START) |=> !pix_valid_reg)
        else $error("start produced a pixel");

    a_pattern_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (take && job.op == slpg_pkg::KIND_STEP && active_reg && styled_reg)
        |=> pos_reg == PB'($past(pos_reg) + 1'b1))
        else $error("pattern position did not advance");

endmodule

`default_nettype wire

>>> hdl/styled_line_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// Styled line pixel generator
// Bresenham line stepper with a 32-bit dash pattern and point output.
// ----------------------------------------------------------------------------
// A pixel is held in the output register after its step or point command has
// passed through the job queue.
// Throughput: one command per cycle while the pixel channel does not stall it.
// A start command produces no pixel; an unused kind is taken and dropped.
// Reset clears the line state and queue and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module styled_line_pixel_generator_unit #(
    parameter int COORD_BITS = slpg_pkg::COORD_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    slpg_cmd_if.sink     cmd,
    slpg_cfg_if.sink     cfg,
    slpg_pixel_if.source pixel
);

    localparam int JOB_BITS = slpg_pkg::job_bits(COORD_BITS);

    logic                fe_valid;
    logic                fe_ready;
    logic [JOB_BITS-1:0] fe_data;
    logic                be_valid;
    logic                be_ready;
    logic [JOB_BITS-1:0] be_data;

    slpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .cmd       (cmd),
        .job_valid (fe_valid),
        .job_ready (fe_ready),
        .job_data  (fe_data)
    );

    slpg_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (slpg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_data  (fe_data),
        .rd_valid (be_valid),
        .rd_ready (be_ready),
        .rd_data  (be_data)
    );

    slpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (be_valid),
        .job_ready (be_ready),
        .job_data  (be_data),
        .cfg       (cfg),
        .pixel     (pixel)
    );

endmodule

`default_nettype wire

>>> tb/slpg_pixel_checker.sv
// ----------------------------------------------------------------------------
// Styled line pixel checker
// Watches the command, configuration and pixel channels of the line
// generator, predicts every pixel from the accepted commands and compares
// each pixel transfer with the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module slpg_pixel_checker #(
    parameter int COORD_BITS = slpg_pkg::COORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    slpg_cmd_if       cmd,
    slpg_cfg_if       cfg,
    slpg_pixel_if     pixel,
    output int        failures,
    output int        pending
);

    typedef logic [COORD_BITS-1:0]           coord_t;
    typedef logic [slpg_pkg::COLOR_BITS-1:0] color_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   draw;
        logic   op;
        color_t color;
        logic   last;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic [slpg_pkg::MODE_BITS-1:0]    mode;
    logic                              dashed;
    logic [slpg_pkg::PATTERN_BITS-1:0] dash_word;
    color_t                            fg;
    color_t                            bg;
    color_t                            xor_value;

    coord_t                            walk_x;
    coord_t                            walk_y;
    coord_t                            target_x;
    coord_t                            target_y;
    int                                err_acc;
    int                                span_dx2;
    int                                span_dy2;
    logic                              x_back;
    logic                              y_back;
    logic                              x_leads;
    logic [slpg_pkg::PAT_POS_BITS-1:0] dash_idx;
    logic                              line_live;

    pixel_t                            want;
    logic                              emitted;

    function automatic coord_t nudge(input coord_t v, input logic back);
        return back ? v - 1'b1 : v + 1'b1;
    endfunction

    function automatic logic color_for_mode(output logic op, output color_t c);
        op = 1'b0;
        c  = '0;
        case (mode)
            slpg_pkg::MODE_FG:  c = fg;
            slpg_pkg::MODE_BG:  c = bg;
            slpg_pkg::MODE_XOR:
            begin
                op = 1'b1;
                c  = xor_value;
            end
            default:  return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic clear_state();
        failures  = 0;
        mode      = slpg_pkg::MODE_FG;
        dashed    = 1'b0;
        dash_word = slpg_pkg::PATTERN_RESET;
        fg        = slpg_pkg::FG_RESET;
        bg        = slpg_pkg::BG_RESET;
        xor_value = slpg_pkg::XOR_RESET;
        walk_x    = '0;
        walk_y    = '0;
        target_x  = '0;
        target_y  = '0;
        err_acc   = 0;
        span_dx2  = 0;
        span_dy2  = 0;
        x_back    = 1'b0;
        y_back    = 1'b0;
        x_leads   = 1'b0;
        dash_idx  = '0;
        line_live = 1'b0;
        expected_pixels.delete();
    endtask

    task automatic write_setting(input logic [slpg_pkg::CFG_INDEX_BITS-1:0] index,
                                 input logic [slpg_pkg::CFG_DATA_BITS-1:0] data);
        case (index)
            slpg_pkg::CFG_WRITE_MODE:    mode      = data[slpg_pkg::MODE_BITS-1:0];
            slpg_pkg::CFG_STYLED_ENABLE: dashed    = data[0];
            slpg_pkg::CFG_LINE_PATTERN:  dash_word = data[slpg_pkg::PATTERN_BITS-1:0];
            slpg_pkg::CFG_FG_COLOR:      fg        = data[slpg_pkg::COLOR_BITS-1:0];
            slpg_pkg::CFG_BG_COLOR:      bg        = data[slpg_pkg::COLOR_BITS-1:0];
            slpg_pkg::CFG_XOR_COLOR:     xor_value = data[slpg_pkg::COLOR_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic predict(input logic [slpg_pkg::KIND_BITS-1:0] kind,
                           input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey,
                           output logic has_pixel, output pixel_t px);
        int   dx;
        int   dy;
        logic ok;
        has_pixel = 1'b0;
        px        = '0;
        case (kind)
            slpg_pkg::KIND_START:
            begin
                dx        = int'(ex) - int'(sx);
                dy        = int'(ey) - int'(sy);
                span_dx2  = (dx < 0 ? -dx : dx) * 2;
                span_dy2  = (dy < 0 ? -dy : dy) * 2;
                x_back    = dx < 0;
                y_back    = dy < 0;
                x_leads   = span_dx2 > span_dy2;
                err_acc   = x_leads ? span_dy2 - span_dx2 / 2 : span_dx2 - span_dy2 / 2;
                walk_x    = sx;
                walk_y    = sy;
                target_x  = ex;
                target_y  = ey;
                dash_idx  = '0;
                line_live = 1'b1;
            end
            slpg_pkg::KIND_POINT:
            begin
                ok        = color_for_mode(px.op, px.color);
                px.x      = sx;
                px.y      = sy;
                px.draw   = ok;
                px.last   = 1'b1;
                has_pixel = 1'b1;
            end
            slpg_pkg::KIND_STEP:
            begin
                if (line_live)
                begin
                    ok = color_for_mode(px.op, px.color);
                    if (dashed)
                    begin
                        px.draw  = dash_word[slpg_pkg::PATTERN_BITS - 1 - dash_idx];
                        dash_idx = dash_idx + 1'b1;
                    end
                    else
                    begin
                        px.draw = 1'b1;
                    end
                    px.x      = walk_x;
                    px.y      = walk_y;
                    px.last   = x_leads ? (walk_x == target_x) : (walk_y == target_y);
                    has_pixel = 1'b1;
                    if (px.last)
                    begin
                        line_live = 1'b0;
                    end
                    else if (x_leads)
                    begin
                        if (err_acc > 0 || (err_acc == 0 && !x_back))
                        begin
                            walk_y  = nudge(walk_y, y_back);
                            err_acc = err_acc - span_dx2;
                        end
                        walk_x  = nudge(walk_x, x_back);
                        err_acc = err_acc + span_dy2;
                    end
                    else
                    begin
                        if (err_acc > 0 || (err_acc == 0 && !y_back))
                        begin
                            walk_x  = nudge(walk_x, x_back);
                            err_acc = err_acc - span_dy2;
                        end
                        walk_y  = nudge(walk_y, y_back);
                        err_acc = err_acc + span_dx2;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int exp_value, input int got_value);
        if (exp_value != got_value)
        begin
            $error("%s: expected %0d, got %0d", name, exp_value, got_value);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel transfer at (%0d, %0d) with no pixel pending",
                           pixel.pixel_x, pixel.pixel_y);
                    failures++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", int'(want.x), int'(pixel.pixel_x));
                    check_field("pixel_y", int'(want.y), int'(pixel.pixel_y));
                    check_field("draw", int'(want.draw), int'(pixel.draw));
                    check_field("pixel_op", int'(want.op), int'(pixel.pixel_op));
                    check_field("color", int'(want.color), int'(pixel.color));
                    check_field("last", int'(want.last), int'(pixel.last));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                write_setting(cfg.index, cfg.data);
            end
            if (cmd.valid && cmd.ready)
            begin
                predict(cmd.kind, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y, emitted, want);
                if (emitted)
                begin
                    expected_pixels.push_back(want);
                end
            end
        end
        pending = expected_pixels.size();
    end

endmodule

`default_nettype wire

>>> tb/styled_line_pixel_generator_unit_test.sv
// ----------------------------------------------------------------------------
// Styled line pixel generator testbench
// Drives start, step and point commands in random bursts under a series of
// register settings, stalls the pixel channel at random, and relies on the
// pixel checker for prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module styled_line_pixel_generator_unit_test;

    localparam int COORD_BITS      = slpg_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX       = (1 << COORD_BITS) - 1;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int PHASES          = 7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RUN_LIMIT_NS    = 10_000_000;

    localparam logic [slpg_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam logic [slpg_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef logic [COORD_BITS-1:0]              coord_t;
    typedef logic [slpg_pkg::COLOR_BITS-1:0]    color_t;
    typedef logic [slpg_pkg::MODE_BITS-1:0]     mode_t;
    typedef logic [slpg_pkg::CFG_DATA_BITS-1:0] cfg_data_t;

    localparam coord_t COORD_TOP = coord_t'(COORD_MAX);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   failures;
    int   pending;
    int   hold_off_req  = 0;
    int   hold_off_seen = 0;
    int   burst_left    = 0;
    int   item_count    = 0;

    slpg_cmd_if   #(.COORD_BITS(COORD_BITS)) cmd();
    slpg_cfg_if                              cfg();
    slpg_pixel_if #(.COORD_BITS(COORD_BITS)) pixel();

    styled_line_pixel_generator_unit #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .pixel (pixel)
    );

    slpg_pixel_checker #(
        .COORD_BITS(COORD_BITS)
    ) u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .pixel    (pixel),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // The receiver normally stalls on a randomly picked pattern; on request it
    // holds off for a long stretch instead.
    initial
    begin
        int cycle;
        int stall_mode;
        pixel.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req != hold_off_seen)
            begin
                hold_off_seen = hold_off_req;
                pixel.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                cycle++;
                if (cycle % 97 == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                end
                case (stall_mode)
                    0:       pixel.ready <= 1'b1;
                    1:       pixel.ready <= 1'($urandom_range(0, 1));
                    2:       pixel.ready <= ($urandom_range(0, 3) == 0);
                    default: pixel.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, COORD_MAX));
    endfunction

    function automatic coord_t pick_coord();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(0, 1) ? COORD_TOP : coord_t'(0);
        end
        return any_coord();
    endfunction

    function automatic coord_t shift_coord(input coord_t base, input int delta);
        int v;
        v = int'(base) + delta;
        if (v < 0 || v > COORD_MAX)
        begin
            v = int'(base) - delta;
        end
        return coord_t'(v);
    endfunction

    function automatic cfg_data_t pad(input cfg_data_t value, input int width);
        return ($urandom() << width) | value;
    endfunction

    task automatic offer(input logic [slpg_pkg::KIND_BITS-1:0] kind,
                         input coord_t sx, input coord_t sy,
                         input coord_t ex, input coord_t ey);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        cmd.valid   <= 1'b1;
        cmd.kind    <= kind;
        cmd.start_x <= sx;
        cmd.start_y <= sy;
        cmd.end_x   <= ex;
        cmd.end_y   <= ey;
        do @(posedge clk); while (!cmd.ready);
        burst_left--;
        if (kind != KIND_UNUSED)
        begin
            item_count++;
        end
    endtask

    task automatic step_line();
        offer(slpg_pkg::KIND_STEP, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input mode_t mode, input logic dashed,
                                  input logic [slpg_pkg::PATTERN_BITS-1:0] dash_word,
                                  input color_t fg,
                                  input color_t bg,
                                  input color_t xor_value);
        logic [slpg_pkg::CFG_INDEX_BITS-1:0] index [6];
        cfg_data_t                           data [6];
        index = '{slpg_pkg::CFG_WRITE_MODE, slpg_pkg::CFG_STYLED_ENABLE,
                  slpg_pkg::CFG_LINE_PATTERN, slpg_pkg::CFG_FG_COLOR,
                  slpg_pkg::CFG_BG_COLOR, slpg_pkg::CFG_XOR_COLOR};
        data  = '{pad(cfg_data_t'(mode), slpg_pkg::MODE_BITS),
                  pad(cfg_data_t'(dashed), 1),
                  cfg_data_t'(dash_word),
                  pad(cfg_data_t'(fg), slpg_pkg::COLOR_BITS),
                  pad(cfg_data_t'(bg), slpg_pkg::COLOR_BITS),
                  pad(cfg_data_t'(xor_value), slpg_pkg::COLOR_BITS)};
        for (int i = 0; i < 6; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= index[i];
            cfg.data  <= data[i];
            do @(posedge clk); while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic random_line();
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        int     span;
        int     dx;
        int     dy;
        int     len;
        int     steps;
        int     sel;
        sx  = pick_coord();
        sy  = pick_coord();
        sel = $urandom_range(0, 99);
        if (sel < 95)
        begin
            span = (sel < 80) ? 12 : 50;
            ex   = shift_coord(sx, int'($urandom_range(0, 2 * span)) - span);
            ey   = shift_coord(sy, int'($urandom_range(0, 2 * span)) - span);
        end
        else
        begin
            ex = pick_coord();
            ey = pick_coord();
        end
        dx  = int'(ex) - int'(sx);
        dy  = int'(ey) - int'(sy);
        dx  = dx < 0 ? -dx : dx;
        dy  = dy < 0 ? -dy : dy;
        len = (dx > dy ? dx : dy) + 1;
        sel = $urandom_range(0, 99);
        if (sel < 85)
        begin
            steps = len;
        end
        else if (sel < 95)
        begin
            steps = len + $urandom_range(1, 3);
        end
        else
        begin
            steps = $urandom_range(1, len);
        end
        if (steps > 64)
        begin
            steps = $urandom_range(1, 64);
        end
        offer(slpg_pkg::KIND_START, sx, sy, ex, ey);
        repeat (steps) step_line();
    endtask

    task automatic directed_items();
        step_line();
        offer(slpg_pkg::KIND_POINT, '0, '0, COORD_TOP, COORD_TOP);
        offer(slpg_pkg::KIND_POINT, COORD_TOP, COORD_TOP, '0, '0);
        offer(KIND_UNUSED, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
        offer(slpg_pkg::KIND_START, COORD_TOP, '0, coord_t'(COORD_MAX - 4), coord_t'(2));
        repeat (5) step_line();
        offer(slpg_pkg::KIND_START, '0, COORD_TOP, coord_t'(2), coord_t'(COORD_MAX - 4));
        repeat (2) step_line();
        offer(slpg_pkg::KIND_START, coord_t'(7), coord_t'(7), coord_t'(7), coord_t'(7));
        repeat (2) step_line();
        offer(slpg_pkg::KIND_START, coord_t'(10), coord_t'(10), coord_t'(14), coord_t'(14));
        repeat (2) step_line();
        offer(slpg_pkg::KIND_POINT, coord_t'(500), coord_t'(600), '0, '0);
        repeat (3) step_line();
    endtask

    initial
    begin
        int target;
        int sel;
        cmd.valid   <= 1'b0;
        cmd.kind    <= slpg_pkg::KIND_START;
        cmd.start_x <= '0;
        cmd.start_y <= '0;
        cmd.end_x   <= '0;
        cmd.end_y   <= '0;
        cfg.valid   <= 1'b0;
        cfg.index   <= slpg_pkg::CFG_WRITE_MODE;
        cfg.data    <= '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        directed_items();

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            drain();
            case (phase)
                1:       apply_settings(slpg_pkg::MODE_FG, 1'b1, $urandom(),
                                        8'hff, 8'h00, 8'h00);
                2:       apply_settings(slpg_pkg::MODE_BG, 1'b1, '0, color_t'($urandom()),
                                        color_t'($urandom()), color_t'($urandom()));
                3:       apply_settings(slpg_pkg::MODE_XOR, 1'b0, $urandom(),
                                        8'h00, 8'hff, 8'hff);
                4:       apply_settings(MODE_UNUSED, 1'b1, slpg_pkg::PATTERN_RESET,
                                        color_t'($urandom()), color_t'($urandom()),
                                        color_t'($urandom()));
                5:       apply_settings(slpg_pkg::MODE_XOR, 1'b1, 32'haaaa_5555,
                                        color_t'($urandom()), color_t'($urandom()),
                                        color_t'($urandom()));
                default: apply_settings(mode_t'($urandom_range(0, 3)),
                                        1'($urandom_range(0, 1)), $urandom(),
                                        color_t'($urandom()), color_t'($urandom()),
                                        color_t'($urandom()));
            endcase
            if (phase == 2)
            begin
                hold_off_req <= hold_off_req + 1;
                burst_left = 60;
            end
            target = item_count + ITEMS_PER_PHASE;
            while (item_count < target)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 75)
                begin
                    random_line();
                end
                else if (sel < 88)
                begin
                    offer(slpg_pkg::KIND_POINT, pick_coord(), pick_coord(),
                          any_coord(), any_coord());
                end
                else if (sel < 94)
                begin
                    step_line();
                end
                else if (sel < 97)
                begin
                    offer(KIND_UNUSED, any_coord(), any_coord(), any_coord(), any_coord());
                end
                else
                begin
                    drain();
                end
            end
        end

        drain();
        if (failures == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> styled_line_pixel_generator_unit.f
hdl/slpg_pkg.sv
hdl/slpg_cmd_if.sv
hdl/slpg_pixel_if.sv
hdl/slpg_cfg_if.sv
hdl/slpg_front.sv
hdl/slpg_queue.sv
hdl/slpg_back.sv
hdl/styled_line_pixel_generator_unit.sv
tb/slpg_pixel_checker.sv
tb/styled_line_pixel_generator_unit_test.sv
